/* rtl/core/cbt_pkg.sv */
// Package for the color blob tracker: payload structs, register indexes, color codes.
// No dependencies; every module of the tracker imports it.
`timescale 1ns / 1ps
`default_nettype none
package cbt_pkg;
    localparam int unsigned CoordBitsDefault = 9;
    localparam int unsigned NumColors = 4;
    localparam int unsigned CountBits = 19;
    localparam int unsigned CfgIdxBits = 3;
    localparam int unsigned CfgDataBits = 19;

    localparam logic [CfgIdxBits-1:0] REG_TARGET = 3'd0;
    localparam logic [CfgIdxBits-1:0] REG_MINPIX = 3'd1;
    localparam logic [CfgIdxBits-1:0] REG_SHIFT = 3'd2;
    localparam logic [CfgIdxBits-1:0] REG_WIDTH = 3'd3;
    localparam logic [CfgIdxBits-1:0] REG_HEIGHT = 3'd4;

    typedef enum logic [2:0] {
        t_col_black = 3'd0, t_col_red = 3'd1, t_col_green = 3'd2,
        t_col_blue = 3'd3, t_col_unknown = 3'd4
    } t_color;

    typedef struct packed {
        logic        kind;
        logic [15:0] pixel;
        logic [8:0]  pos_x;
        logic [8:0]  pos_y;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [8:0]  box_x;
        logic [8:0]  box_y;
        logic [9:0]  box_w;
        logic [9:0]  box_h;
        logic [8:0]  center_x;
        logic [8:0]  center_y;
        logic [18:0] area;
    } t_out_item;

    // One classified beat handed from the front to the back.
    typedef struct packed {
        logic        eof;
        logic        use_px;
        logic [1:0]  color;
        logic [8:0]  pos_x;
        logic [8:0]  pos_y;
    } t_cls_item;
endpackage
`default_nettype wire

/* rtl/core/color_blob_tracker_core.sv */
// Top level of the color blob tracker: registers, front, queue and back.
// Depends on cbt_pkg, cbt_front, cbt_queue, cbt_back.
`timescale 1ns / 1ps
`default_nettype none
// In the front, a used pixel beat passes through the shared one-bit-per-cycle divider that
// forms saturation and then hue; an unused pixel or end-of-frame beat skips it. An
// end-of-frame beat holds the back for 28 steps of bit-serial centroid division and a
// final step that forms the result, before its result beat appears. The back
// accumulates one beat per cycle while it is not dividing or holding a result.
module color_blob_tracker_core (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire cbt_pkg::t_in_item       i_data,
    output logic                         empty,
    input  wire logic                    pop,
    output cbt_pkg::t_out_item           o_data,
    input  wire logic                    i_cfg_we,
    input  wire logic [cbt_pkg::CfgIdxBits-1:0]  i_cfg_idx,
    input  wire logic [cbt_pkg::CfgDataBits-1:0] i_cfg_data
);
    import cbt_pkg::*;
    logic [1:0] r_target, r_shift;
    logic [18:0] r_min_pix;
    logic [9:0] r_width, r_height;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= 2'd1; r_min_pix <= 19'd32; r_shift <= 2'd1;
            r_width <= 10'd320; r_height <= 10'd240;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TARGET: r_target <= i_cfg_data[1:0];
                REG_MINPIX: r_min_pix <= i_cfg_data[18:0];
                REG_SHIFT:  r_shift <= i_cfg_data[1:0];
                REG_WIDTH:  r_width <= i_cfg_data[9:0];
                REG_HEIGHT: r_height <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    logic f_rdy, f_vld, q_rdy, q_vld, b_rdy, b_vld;
    t_cls_item f_item, q_item;
    assign full = !f_rdy;
    assign empty = !b_vld;

    cbt_front u_front (
        .i_clk, .i_rst_n, .i_valid(push), .i_item(i_data), .o_ready(f_rdy),
        .i_shift(r_shift), .i_width(r_width), .i_height(r_height),
        .o_valid(f_vld), .o_item(f_item), .i_ready(q_rdy)
    );
    cbt_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_vld), .i_item(f_item), .o_ready(q_rdy),
        .o_valid(q_vld), .o_item(q_item), .i_ready(b_rdy)
    );
    cbt_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_vld), .i_item(q_item), .o_ready(b_rdy),
        .i_target(r_target), .i_min_pix(r_min_pix), .i_width(r_width),
        .i_height(r_height), .o_valid(b_vld), .o_item(o_data), .i_ready(pop)
    );
endmodule
`default_nettype wire

/* rtl/core/cbt_front.sv */
// Front: samples, converts RGB565 to HSV and classifies pixels, one beat at a time.
// Depends on cbt_pkg. Stage one expands and finds max/min, stage two divides (by a
// shared sequential divider), stage three classifies.
`timescale 1ns / 1ps
`default_nettype none
module cbt_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire cbt_pkg::t_in_item i_item,
    output logic                   o_ready,
    input  wire logic [1:0]        i_shift,
    input  wire logic [9:0]        i_width,
    input  wire logic [9:0]        i_height,
    output logic                   o_valid,
    output cbt_pkg::t_cls_item     o_item,
    input  wire logic              i_ready
);
    import cbt_pkg::*;

    typedef enum logic [1:0] {t_fs_idle, t_fs_divs, t_fs_divh, t_fs_out} t_fstate;

    t_fstate r_st, n_st;
    t_in_item r_in;
    logic [7:0] r_r, r_g, r_b, r_mx, r_mn;
    logic r_use;
    logic [15:0] r_num, r_quo;
    logic [8:0] r_den;
    logic [3:0] r_cnt;
    logic [7:0] r_s;
    logic signed [9:0] r_h;
    logic r_neg;
    logic [8:0] r_hbase;

    logic [7:0] c_r, c_g, c_b, c_mx, c_mn, diff;
    logic [12:0] er, eb;
    logic [13:0] eg;
    logic [9:0] step_mask;
    logic c_use;

    always_comb begin
        er = 13'(i_item.pixel[15:11]) * 13'd255;
        eg = 14'(i_item.pixel[10:5]) * 14'd255;
        eb = 13'(i_item.pixel[4:0]) * 13'd255;
        // Exact for these ranges: x/31 and x/63 via small reciprocal products.
        c_r = 8'((er * 29'd33826) >> 20);
        c_g = 8'((eg * 29'd16645) >> 20);
        c_b = 8'((eb * 29'd33826) >> 20);
        c_mx = c_r; c_mn = c_r;
        if (c_g > c_mx) c_mx = c_g;
        if (c_b > c_mx) c_mx = c_b;
        if (c_g < c_mn) c_mn = c_g;
        if (c_b < c_mn) c_mn = c_b;
        step_mask = (10'd1 << i_shift) - 10'd1;
        c_use = ({1'b0, i_item.pos_x} < i_width) && ({1'b0, i_item.pos_y} < i_height)
              && ((10'(i_item.pos_x) & step_mask) == '0)
              && ((10'(i_item.pos_y) & step_mask) == '0);
    end

    assign diff = r_mx - r_mn;
    assign o_ready = (r_st == t_fs_idle);

    // Hue numerator: 60 * |difference| with its sign and base remembered.
    logic [8:0] hd;
    logic hneg;
    logic [8:0] hbase;
    always_comb begin
        hd = '0; hneg = 1'b0; hbase = '0;
        if (r_mx == r_r) begin
            hneg = r_g < r_b; hd = hneg ? 9'(r_b - r_g) : 9'(r_g - r_b); hbase = 9'd0;
        end else if (r_mx == r_g) begin
            hneg = r_b < r_r; hd = hneg ? 9'(r_r - r_b) : 9'(r_b - r_r); hbase = 9'd120;
        end else begin
            hneg = r_r < r_g; hd = hneg ? 9'(r_g - r_r) : 9'(r_r - r_g); hbase = 9'd240;
        end
    end

    logic [16:0] trial;
    assign trial = {r_quo[15:0], r_num[15]} - 17'(r_den);

    always_comb begin
        n_st = r_st;
        case (r_st)
            t_fs_idle: if (i_valid) n_st = (i_item.kind || !c_use) ? t_fs_out : t_fs_divs;
            t_fs_divs: if (r_cnt == 4'd15) n_st = t_fs_divh;
            t_fs_divh: if (r_cnt == 4'd15) n_st = t_fs_out;
            t_fs_out:  if (i_ready) n_st = t_fs_idle;
            default:   n_st = t_fs_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= t_fs_idle;
        else r_st <= n_st;
        case (r_st)
            t_fs_idle: begin
                r_in <= i_item; r_use <= c_use && !i_item.kind;
                r_r <= c_r; r_g <= c_g; r_b <= c_b; r_mx <= c_mx; r_mn <= c_mn;
                r_num <= 16'(c_mx - c_mn) * 16'd255;
                r_den <= {1'b0, c_mx};
                r_quo <= '0; r_cnt <= '0;
            end
            t_fs_divs, t_fs_divh: begin
                // Restoring division, one quotient bit per cycle; r_quo holds the remainder
                // while r_num shifts out numerator bits and shifts in quotient bits.
                r_cnt <= r_cnt + 4'd1;
                if (!trial[16]) r_quo <= trial[15:0];
                else r_quo <= {r_quo[14:0], r_num[15]};
                r_num <= {r_num[14:0], !trial[16]};
                if (r_cnt == 4'd15) begin
                    if (r_st == t_fs_divs) begin
                        r_s <= (r_mx == 8'd0) ? 8'd0 : 8'({r_num[14:0], !trial[16]});
                        r_num <= 16'(hd) * 16'd60;
                        r_den <= {1'b0, diff};
                        r_neg <= hneg; r_hbase <= hbase;
                        r_quo <= '0;
                    end else begin
                        r_h <= (diff == 8'd0) ? 10'sd0 :
                            (r_neg ? 10'(r_hbase) - 10'({r_num[14:0], !trial[16]})
                                   : 10'(r_hbase) + 10'({r_num[14:0], !trial[16]}));
                    end
                end
            end
            default: ;
        endcase
    end

    logic signed [9:0] h;
    t_color col;
    always_comb begin
        h = (r_h < 0) ? r_h + 10'sd360 : r_h;
        if (r_mx <= 8'd70 && r_s <= 8'd130) col = t_col_black;
        else if (r_mx < 8'd45 || r_s < 8'd45) col = t_col_unknown;
        else if ((h >= 0 && h <= 18) || (h >= 340 && h <= 359)) col = t_col_red;
        else if (h >= 70 && h <= 165) col = t_col_green;
        else if (h >= 185 && h <= 260) col = t_col_blue;
        else col = t_col_unknown;
        o_valid = (r_st == t_fs_out);
        o_item.eof = r_in.kind;
        o_item.use_px = r_use && (col != t_col_unknown);
        o_item.color = col[1:0];
        o_item.pos_x = r_in.pos_x;
        o_item.pos_y = r_in.pos_y;
    end
endmodule
`default_nettype wire

/* rtl/core/cbt_queue.sv */
// Two-entry queue between front and back.
// Depends on cbt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbt_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire cbt_pkg::t_cls_item i_item,
    output logic                    o_ready,
    output logic                    o_valid,
    output cbt_pkg::t_cls_item      o_item,
    input  wire logic               i_ready
);
    import cbt_pkg::*;
    t_cls_item r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_n;
    logic wr, rd;
    assign o_ready = r_n != 2'd2;
    assign o_valid = r_n != 2'd0;
    assign o_item = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_n <= '0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_n <= r_n + 2'(wr) - 2'(rd);
        end
    end
endmodule
`default_nettype wire

/* rtl/core/cbt_back.sv */
// Back: per-color statistics, frame-end report with sequential centroid division.
// Depends on cbt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbt_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire cbt_pkg::t_cls_item i_item,
    output logic                    o_ready,
    input  wire logic [1:0]         i_target,
    input  wire logic [18:0]        i_min_pix,
    input  wire logic [9:0]         i_width,
    input  wire logic [9:0]         i_height,
    output logic                    o_valid,
    output cbt_pkg::t_out_item      o_item,
    input  wire logic               i_ready
);
    import cbt_pkg::*;
    localparam int unsigned COORD_BITS = CoordBitsDefault;
    localparam int unsigned SumBits = CountBits + COORD_BITS;
    localparam int unsigned DivSteps = SumBits;
    localparam logic [CountBits-1:0] CountMax = '1;

    typedef enum logic [1:0] {t_bs_run, t_bs_div, t_bs_out} t_bstate;

    t_bstate r_st, n_st;
    logic [CountBits-1:0]  r_cnt [NumColors];
    logic [SumBits-1:0]    r_sx [NumColors], r_sy [NumColors];
    logic [COORD_BITS-1:0] r_mnx [NumColors], r_mny [NumColors];
    logic [COORD_BITS-1:0] r_mxx [NumColors], r_mxy [NumColors];
    logic [SumBits-1:0] r_qx, r_qy, r_rx, r_ry;
    logic [$clog2(DivSteps+1)-1:0] r_step;
    t_out_item r_out;
    logic r_found;

    logic [CountBits-1:0] den, tc;
    logic [SumBits:0] tx, ty;
    logic clr, upd;
    assign tc = r_cnt[i_target];
    assign den = (tc == '0) ? CountBits'(1) : tc;
    assign tx = {r_rx, r_qx[SumBits-1]} - (SumBits+1)'(den);
    assign ty = {r_ry, r_qy[SumBits-1]} - (SumBits+1)'(den);
    assign o_ready = (r_st == t_bs_run);
    assign o_valid = (r_st == t_bs_out);
    assign o_item = r_out;
    assign upd = i_valid && o_ready && !i_item.eof && i_item.use_px
                 && r_cnt[i_item.color] != CountMax;
    assign clr = (r_st == t_bs_out) && i_ready;

    always_comb begin
        n_st = r_st;
        case (r_st)
            t_bs_run: if (i_valid && i_item.eof) n_st = t_bs_div;
            t_bs_div: if (r_step == ($bits(r_step))'(DivSteps)) n_st = t_bs_out;
            t_bs_out: if (i_ready) n_st = t_bs_run;
            default:  n_st = t_bs_run;
        endcase
    end

    logic [COORD_BITS-1:0] px, py;
    logic [9:0] hx, hy, cx, cy, bw, bh;
    logic signed [COORD_BITS+1:0] dw, dh;
    always_comb begin
        px = COORD_BITS'(i_item.pos_x);
        py = COORD_BITS'(i_item.pos_y);
        hx = (i_width == '0) ? 10'd0 : i_width - 10'd1;
        hy = (i_height == '0) ? 10'd0 : i_height - 10'd1;
        cx = (r_qx > SumBits'(hx)) ? hx : 10'(r_qx);
        cy = (r_qy > SumBits'(hy)) ? hy : 10'(r_qy);
        dw = $signed({2'b0, r_mxx[i_target]}) - $signed({2'b0, r_mnx[i_target]});
        dh = $signed({2'b0, r_mxy[i_target]}) - $signed({2'b0, r_mny[i_target]});
        bw = (dw < 0) ? 10'd1 : 10'(dw + 1);
        bh = (dh < 0) ? 10'd1 : 10'(dh + 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= t_bs_run;
        else r_st <= n_st;
        if (r_st == t_bs_run) begin
            r_qx <= r_sx[i_target]; r_qy <= r_sy[i_target];
            r_rx <= '0; r_ry <= '0; r_step <= '0;
            r_found <= tc >= i_min_pix;
        end
        if (r_st == t_bs_div && r_step != ($bits(r_step))'(DivSteps)) begin
            r_step <= r_step + 1'b1;
            r_rx <= tx[SumBits] ? {r_rx[SumBits-2:0], r_qx[SumBits-1]} : tx[SumBits-1:0];
            r_ry <= ty[SumBits] ? {r_ry[SumBits-2:0], r_qy[SumBits-1]} : ty[SumBits-1:0];
            r_qx <= {r_qx[SumBits-2:0], !tx[SumBits]};
            r_qy <= {r_qy[SumBits-2:0], !ty[SumBits]};
        end
        if (r_st == t_bs_div && r_step == ($bits(r_step))'(DivSteps)) begin
            r_out <= '0;
            if (r_found) begin
                r_out.found <= 1'b1;
                r_out.box_x <= 9'(r_mnx[i_target]);
                r_out.box_y <= 9'(r_mny[i_target]);
                r_out.box_w <= bw; r_out.box_h <= bh;
                r_out.center_x <= 9'(cx); r_out.center_y <= 9'(cy);
                r_out.area <= tc;
            end
        end
        for (int i = 0; i < NumColors; i++) begin
            if (!i_rst_n || clr) begin
                r_cnt[i] <= '0; r_sx[i] <= '0; r_sy[i] <= '0;
                r_mnx[i] <= '1; r_mny[i] <= '1; r_mxx[i] <= '0; r_mxy[i] <= '0;
            end else if (upd && i_item.color == 2'(i)) begin
                r_cnt[i] <= r_cnt[i] + 1'b1;
                r_sx[i] <= r_sx[i] + SumBits'(px);
                r_sy[i] <= r_sy[i] + SumBits'(py);
                if (px < r_mnx[i]) r_mnx[i] <= px;
                if (py < r_mny[i]) r_mny[i] <= py;
                if (px > r_mxx[i]) r_mxx[i] <= px;
                if (py > r_mxy[i]) r_mxy[i] <= py;
            end
        end
    end
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Testbench for color_blob_tracker_core: drives pixel and end-of-frame beats, keeps
// its own blob statistics per color and checks every reported blob. Depends on cbt_pkg.
`timescale 1ns / 1ps
module tb_top;
    import cbt_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    t_in_item   i_data = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_out_item  o_data;
    logic       i_cfg_we = 1'b0;
    logic [CfgIdxBits-1:0]  i_cfg_idx = '0;
    logic [CfgDataBits-1:0] i_cfg_data = '0;

    color_blob_tracker_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_data(i_data),
        .empty(empty), .pop(pop), .o_data(o_data), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Register copies and per-color blob statistics.
    int unsigned tgt_color, min_pix, shift_sel, width_px, height_px;
    int unsigned blob_count[4], blob_sum_x[4], blob_sum_y[4];
    int unsigned blob_min_x[4], blob_min_y[4], blob_max_x[4], blob_max_y[4];
    t_out_item   blob_reports[$];
    int          mismatches = 0;

    function automatic t_color color_of(logic [15:0] px);
        int r, g, b, mx, mn, diff, h, s, v;
        r = int'(px[15:11]) * 255 / 31;
        g = int'(px[10:5]) * 255 / 63;
        b = int'(px[4:0]) * 255 / 31;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        diff = mx - mn;
        v = mx;
        s = (mx == 0) ? 0 : 255 * diff / mx;
        if (diff == 0) h = 0;
        else if (mx == r) h = 60 * (g - b) / diff;
        else if (mx == g) h = 120 + 60 * (b - r) / diff;
        else h = 240 + 60 * (r - g) / diff;
        if (h < 0) h += 360;
        if (v <= 70 && s <= 130) return t_col_black;
        if (v < 45 || s < 45) return t_col_unknown;
        if (h <= 18 || (h >= 340 && h <= 359)) return t_col_red;
        if (h >= 70 && h <= 165) return t_col_green;
        if (h >= 185 && h <= 260) return t_col_blue;
        return t_col_unknown;
    endfunction

    function automatic void clear_blobs();
        for (int c = 0; c < 4; c++) begin
            blob_count[c] = 0; blob_sum_x[c] = 0; blob_sum_y[c] = 0;
            blob_min_x[c] = 511; blob_min_y[c] = 511;
            blob_max_x[c] = 0; blob_max_y[c] = 0;
        end
    endfunction

    function automatic void track_beat(t_in_item it);
        int unsigned x, y, mask, bw, bh, cx, cy, div, cnt, t;
        t_color c;
        t_out_item rep;
        if (!it.kind) begin
            x = 32'(it.pos_x); y = 32'(it.pos_y);
            mask = (1 << shift_sel) - 1;
            if (x >= width_px || y >= height_px) return;
            if ((x & mask) != 0 || (y & mask) != 0) return;
            c = color_of(it.pixel);
            if (c == t_col_unknown) return;
            if (blob_count[c] >= 32'h7FFFF) return;
            blob_count[c]++;
            blob_sum_x[c] += x;
            blob_sum_y[c] += y;
            if (x < blob_min_x[c]) blob_min_x[c] = x;
            if (y < blob_min_y[c]) blob_min_y[c] = y;
            if (x > blob_max_x[c]) blob_max_x[c] = x;
            if (y > blob_max_y[c]) blob_max_y[c] = y;
            return;
        end
        rep = '0;
        t = tgt_color;
        cnt = blob_count[t];
        if (cnt >= min_pix) begin
            bw = (blob_max_x[t] >= blob_min_x[t]) ? blob_max_x[t] - blob_min_x[t] + 1 : 1;
            bh = (blob_max_y[t] >= blob_min_y[t]) ? blob_max_y[t] - blob_min_y[t] + 1 : 1;
            div = cnt ? cnt : 1;
            cx = blob_sum_x[t] / div;
            cy = blob_sum_y[t] / div;
            if (cx > (width_px ? width_px - 1 : 0)) cx = width_px ? width_px - 1 : 0;
            if (cy > (height_px ? height_px - 1 : 0)) cy = height_px ? height_px - 1 : 0;
            rep.found = 1'b1;
            rep.box_x = 9'(blob_min_x[t]);
            rep.box_y = 9'(blob_min_y[t]);
            rep.box_w = 10'(bw);
            rep.box_h = 10'(bh);
            rep.center_x = 9'(cx);
            rep.center_y = 9'(cy);
            rep.area = 19'(cnt);
        end
        blob_reports.push_back(rep);
        clear_blobs();
    endfunction

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // Sends one beat after a random gap; the model is updated at acceptance.
    task automatic send_beat(t_in_item it, bit with_gap = 1);
        int unsigned g;
        g = with_gap ? gap_len() : 0;
        repeat (g) @(negedge i_clk);
        push = 1'b1;
        i_data = it;
        do @(posedge i_clk); while (full);
        track_beat(it);
        @(negedge i_clk);
        push = 1'b0;
        i_data = '0;
    endtask

    task automatic send_pixel(logic [15:0] px, logic [8:0] x, logic [8:0] y);
        t_in_item it;
        it = '{kind: 1'b0, pixel: px, pos_x: x, pos_y: y};
        send_beat(it);
    endtask

    task automatic send_eof();
        t_in_item it;
        it = '{kind: 1'b1, pixel: 16'($urandom), pos_x: 9'($urandom), pos_y: 9'($urandom)};
        send_beat(it);
    endtask

    // Waits for all reports, then lets the block drain before touching registers.
    task automatic wait_idle();
        while (blob_reports.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        case (idx)
            REG_TARGET: tgt_color = val & 3;
            REG_MINPIX: min_pix = 32'(val);
            REG_SHIFT:  shift_sel = val & 3;
            REG_WIDTH:  width_px = val & 10'h3FF;
            REG_HEIGHT: height_px = val & 10'h3FF;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_frame(int unsigned tc, int unsigned mp, int unsigned sh,
                             int unsigned w, int unsigned h);
        write_reg(REG_TARGET, CfgDataBits'(tc));
        write_reg(REG_MINPIX, CfgDataBits'(mp));
        write_reg(REG_SHIFT, CfgDataBits'(sh));
        write_reg(REG_WIDTH, CfgDataBits'(w));
        write_reg(REG_HEIGHT, CfgDataBits'(h));
    endtask

    // Reset settings first, then one pixel of each color class and the edge cases.
    task automatic test_directed();
        send_pixel(16'hF800, 0, 0);
        send_pixel(16'h07E0, 2, 2);
        send_pixel(16'h001F, 4, 4);
        send_pixel(16'h0000, 6, 6);
        send_pixel(16'hFFFF, 8, 8);
        send_pixel(16'h8410, 10, 10);
        send_pixel(16'hFFE0, 12, 12);
        send_pixel(16'hF800, 3, 4);
        send_pixel(16'hF800, 320, 0);
        send_pixel(16'hF800, 0, 240);
        send_pixel(16'hF800, 511, 511);
        send_eof();
        wait_idle();
        set_frame(int'(t_col_black), 1, 0, 512, 512);
        send_pixel(16'h001F, 511, 511);
        send_pixel(16'h0000, 0, 511);
        send_pixel(16'h0000, 511, 0);
        send_pixel(16'h0000, 0, 0);
        send_eof();
        wait_idle();
        // Empty target with a zero minimum, and a zero-size frame.
        set_frame(3, 0, 3, 0, 0);
        send_pixel(16'h001F, 0, 0);
        send_eof();
        wait_idle();
        // High data bits beyond a register's width, and indexes past the list.
        write_reg(REG_TARGET, 19'h7FFFE);
        write_reg(3'd5, 19'h00001);
        write_reg(3'd7, 19'h7FFFF);
        set_frame(2, 262144, 2, 1, 1);
        send_pixel(16'h07E0, 0, 0);
        send_eof();
        wait_idle();
    endtask

    function automatic logic [15:0] pick_pixel();
        case ($urandom_range(7))
            0: return 16'hF800 | 16'($urandom_range(31));
            1: return 16'h07E0 | 16'($urandom_range(31) << 11);
            2: return 16'h001F | 16'($urandom_range(63) << 5);
            3: return 16'($urandom_range(16'h3FFF));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_random(int unsigned beats);
        int unsigned sent, n, w, h, sh, step;
        sent = 0;
        while (sent < beats) begin
            sh = $urandom_range(3);
            w = ($urandom_range(9) == 0) ? $urandom_range(512) : $urandom_range(64, 1);
            h = ($urandom_range(9) == 0) ? $urandom_range(512) : $urandom_range(64, 1);
            set_frame($urandom_range(3), $urandom_range(6), sh, w, h);
            step = 1 << sh;
            repeat ($urandom_range(4, 1)) begin
                n = $urandom_range(40);
                repeat (n) begin
                    if ($urandom_range(4) == 0)
                        send_pixel(pick_pixel(), 9'($urandom), 9'($urandom));
                    else
                        send_pixel(pick_pixel(),
                                   9'($urandom_range((w > 0 ? w - 1 : 0) / step) * step),
                                   9'($urandom_range((h > 0 ? h - 1 : 0) / step) * step));
                end
                send_eof();
                sent += n + 1;
            end
            wait_idle();
        end
    endtask

    // Result side: random stalls, compare each popped beat with the oldest report.
    int unsigned pop_hold = 0;
    always @(negedge i_clk) begin
        if (pop_hold != 0) begin
            pop_hold--;
            pop = 1'b0;
        end else begin
            pop_hold = gap_len();
            pop = (pop_hold == 0) || ($urandom_range(1) == 0);
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_rep;
        if (i_rst_n && pop && !empty) begin
            if (blob_reports.size() == 0) begin
                $error("result beat with no report pending");
                mismatches++;
            end else begin
                exp_rep = blob_reports.pop_front();
                if (o_data.found !== exp_rep.found) begin
                    $error("found: expected %0d, got %0d", exp_rep.found, o_data.found);
                    mismatches++;
                end
                if (o_data.box_x !== exp_rep.box_x) begin
                    $error("box_x: expected %0d, got %0d", exp_rep.box_x, o_data.box_x);
                    mismatches++;
                end
                if (o_data.box_y !== exp_rep.box_y) begin
                    $error("box_y: expected %0d, got %0d", exp_rep.box_y, o_data.box_y);
                    mismatches++;
                end
                if (o_data.box_w !== exp_rep.box_w) begin
                    $error("box_w: expected %0d, got %0d", exp_rep.box_w, o_data.box_w);
                    mismatches++;
                end
                if (o_data.box_h !== exp_rep.box_h) begin
                    $error("box_h: expected %0d, got %0d", exp_rep.box_h, o_data.box_h);
                    mismatches++;
                end
                if (o_data.center_x !== exp_rep.center_x) begin
                    $error("center_x: expected %0d, got %0d", exp_rep.center_x,
                           o_data.center_x);
                    mismatches++;
                end
                if (o_data.center_y !== exp_rep.center_y) begin
                    $error("center_y: expected %0d, got %0d", exp_rep.center_y,
                           o_data.center_y);
                    mismatches++;
                end
                if (o_data.area !== exp_rep.area) begin
                    $error("area: expected %0d, got %0d", exp_rep.area, o_data.area);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        tgt_color = 1; min_pix = 32; shift_sel = 1; width_px = 320; height_px = 240;
        clear_blobs();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(1100);
        wait_idle();
        if (mismatches == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
